// ===== design/k_nearest_neighbor_select_macros.svh =====
// ----------------------------------------------------------------------------
// k_nearest_neighbor_select_macros.svh
// Assertion helpers shared by the nearest neighbor selector.
// ----------------------------------------------------------------------------
`ifndef K_NEAREST_NEIGHBOR_SELECT_MACROS_SVH
`define K_NEAREST_NEIGHBOR_SELECT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KNN_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("knn same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KNN_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("knn next-cycle check failed");

`endif

// ===== design/knn_pkg.sv =====
// ----------------------------------------------------------------------------
// knn_pkg
// Shared widths, codes and types of the nearest neighbor selector.
// ----------------------------------------------------------------------------
package knn_pkg;

    // Sizes of the point store and of the sorted neighbor list.
    localparam int MAX_POINTS    = 1024;
    localparam int MAX_NEIGHBORS = 16;
    localparam int COORD_W       = 16;

    // Field widths.
    localparam int POINT_W = $clog2(MAX_POINTS);
    localparam int DIST_W  = 2 * COORD_W + 1;
    localparam int RANK_W  = 4;
    localparam int KCFG_W  = 5;
    localparam int PCFG_W  = 11;
    localparam int NBR_W   = $clog2(MAX_NEIGHBORS + 1);

    // Request kinds carried on s_tuser.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_NEIGHBOR_COUNT = 1'b0;
    localparam logic CFG_POINT_COUNT    = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NODE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT,
        ST_NONE
    } knn_state_t;

    // One candidate or one kept neighbor.
    typedef struct packed {
        logic               valid;
        logic [DIST_W-1:0]  sq_dist;
        logic [POINT_W-1:0] idx;
    } entry_t;

    // What a cell hands to its right neighbor.
    typedef struct packed {
        entry_t ent;
        logic   beat;
    } knn_link_t;

endpackage

// ===== design/knn_dist.sv =====
// ----------------------------------------------------------------------------
// knn_dist
// Three-stage squared distance pipeline: absolute differences, squares, sum.
// ----------------------------------------------------------------------------
module knn_dist (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    input  logic [knn_pkg::POINT_W-1:0]          in_idx,
    input  logic signed [knn_pkg::COORD_W-1:0]   node_x,
    input  logic signed [knn_pkg::COORD_W-1:0]   node_y,
    input  logic signed [knn_pkg::COORD_W-1:0]   pt_x,
    input  logic signed [knn_pkg::COORD_W-1:0]   pt_y,
    output knn_pkg::entry_t                      cand
);
    import knn_pkg::*;

    logic signed [COORD_W:0] diff_x, diff_y;
    logic [COORD_W-1:0]      abs_x_next, abs_y_next;
    logic [COORD_W-1:0]      abs_x_reg, abs_y_reg;
    logic [2*COORD_W-1:0]    sq_x_reg, sq_y_reg;
    logic [POINT_W-1:0]      idx_a_reg, idx_b_reg;
    logic                    valid_a_reg, valid_b_reg;
    logic                    cand_valid_reg;
    logic [DIST_W-1:0]       cand_dist_reg;
    logic [POINT_W-1:0]      cand_idx_reg;

    // Differences are one bit wider; their magnitude fits the coordinate width.
    always_comb begin
        diff_x     = {pt_x[COORD_W-1], pt_x} - {node_x[COORD_W-1], node_x};
        diff_y     = {pt_y[COORD_W-1], pt_y} - {node_y[COORD_W-1], node_y};
        abs_x_next = diff_x[COORD_W] ? COORD_W'(-diff_x) : COORD_W'(diff_x);
        abs_y_next = diff_y[COORD_W] ? COORD_W'(-diff_y) : COORD_W'(diff_y);
    end

    // Pipeline control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg    <= 1'b0;
            valid_b_reg    <= 1'b0;
            cand_valid_reg <= 1'b0;
        end else begin
            valid_a_reg    <= in_valid;
            valid_b_reg    <= valid_a_reg;
            cand_valid_reg <= valid_b_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge aclk) begin
        abs_x_reg     <= abs_x_next;
        abs_y_reg     <= abs_y_next;
        idx_a_reg     <= in_idx;
        sq_x_reg      <= abs_x_reg * abs_x_reg;
        sq_y_reg      <= abs_y_reg * abs_y_reg;
        idx_b_reg     <= idx_a_reg;
        cand_dist_reg <= {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
        cand_idx_reg  <= idx_b_reg;
    end

    assign cand = {cand_valid_reg, cand_dist_reg, cand_idx_reg};

endmodule

// ===== design/knn_cell.sv =====
// ----------------------------------------------------------------------------
// knn_cell
// One slot of the sorted neighbor list: insertion from the left, shift-out
// toward the head.
// ----------------------------------------------------------------------------
module knn_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               enable,
    input  logic               clear,
    input  logic               shift,
    input  knn_pkg::entry_t    cand,
    input  knn_pkg::knn_link_t left_in,
    input  knn_pkg::entry_t    right_in,
    output knn_pkg::knn_link_t link_out
);
    import knn_pkg::*;

    entry_t ent_reg, ent_next;
    logic   beat;

    // A candidate beats this slot when the slot is empty or strictly farther;
    // equal distances keep the earlier, smaller index in front.
    assign beat = cand.valid && (!ent_reg.valid || (cand.sq_dist < ent_reg.sq_dist));

    // Clear; on a shift take the right entry; else take the left entry when
    // the candidate lands further left, the candidate if it lands here, or hold.
    always_comb begin
        ent_next = ent_reg;
        if (clear) begin
            ent_next = '0;
        end else if (shift) begin
            ent_next = right_in;
        end else if (cand.valid && enable) begin
            if (left_in.beat) begin
                ent_next = left_in.ent;
            end else if (beat) begin
                ent_next = cand;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg <= '0;
        end else begin
            ent_reg <= ent_next;
        end
    end

    assign link_out = {ent_reg, beat};

endmodule

// ===== design/k_nearest_neighbor_select.sv =====
// ----------------------------------------------------------------------------
// k_nearest_neighbor_select
// Exact k-nearest-neighbor search over a store of 2D integer points.
// ----------------------------------------------------------------------------
// A load request writes one point. A query request reads the node, then
// streams every stored point below point_count through the single read
// port of the point memory at one point per cycle. The first result of a
// query appears after the node read, the scan, the drain of the read stage
// and the distance pipeline, and the load of the output register; later
// results follow while the output side takes them. The distance pipeline
// feeds a row of MAX_NEIGHBORS sorting cells that keeps the k nearest
// points in order; the results then shift out of the head cell. The block
// takes no new request while a query is running, but a new request is
// accepted while the final result of the previous query still waits on
// the output.
// ----------------------------------------------------------------------------
`include "k_nearest_neighbor_select_macros.svh"

module k_nearest_neighbor_select (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Configuration write channel.
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [knn_pkg::PCFG_W-1:0] cfg_data,
    // Request stream.
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [47:0]                s_tdata,  // point_index, coord_x, coord_y, zero fill
    input  logic                       s_tuser,  // command
    // Result stream.
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [47:0]                m_tdata,  // neighbor_index, squared_distance, rank, zero fill
    output logic                       m_tuser,  // found
    output logic                       m_tlast
);
    import knn_pkg::*;

    localparam int DRAIN_CYCLES = 4;
    localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);
    localparam int X_LSB        = POINT_W;
    localparam int Y_LSB        = POINT_W + COORD_W;

    // Configuration registers.
    logic [KCFG_W-1:0] neighbor_count_reg;
    logic [PCFG_W-1:0] point_count_reg;

    // Request fields.
    logic [POINT_W-1:0] s_point_index;
    logic [COORD_W-1:0] s_coord_x, s_coord_y;
    logic               s_accept;

    // Sequencer.
    knn_state_t         state_reg, state_next;
    logic [PCFG_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic [DRAIN_W-1:0] drain_cnt_reg, drain_cnt_next;
    logic [RANK_W-1:0]  rank_reg, rank_next;
    logic [POINT_W-1:0] node_idx_reg;
    logic [PCFG_W-1:0]  pc_reg;
    logic [NBR_W-1:0]   k_eff_reg, k_eff_next;
    logic [PCFG_W-1:0]  pc_clamp, pc_minus1, k_lim;
    logic               query_empty;
    logic               cells_clear, cells_shift;
    logic               issue_valid;
    logic               mem_we;
    logic [POINT_W-1:0] rd_addr;

    // Point memory and its read stage.
    logic [2*COORD_W-1:0] point_mem [MAX_POINTS];
    logic [2*COORD_W-1:0] rd_data_reg;
    logic                 rd_valid_reg;
    logic [POINT_W-1:0]   rd_idx_reg;
    logic signed [COORD_W-1:0] node_x_reg, node_y_reg;

    // Candidate and sorting row.
    entry_t    cand;
    knn_link_t cell_link [MAX_NEIGHBORS];
    entry_t    right_ent [MAX_NEIGHBORS];

    // Output register.
    logic              out_free, out_load;
    logic              m_tvalid_reg;
    logic [POINT_W-1:0] out_idx_reg, out_idx_next;
    logic [DIST_W-1:0] out_dist_reg, out_dist_next;
    logic [RANK_W-1:0] out_rank_reg, out_rank_next;
    logic              out_found_reg, out_found_next;
    logic              out_last_reg, out_last_next;

    // Terms used by the checks.
    logic              row_in_order, scan_phase, emit_last;

    assign s_point_index = s_tdata[POINT_W-1:0];
    assign s_coord_x     = s_tdata[X_LSB +: COORD_W];
    assign s_coord_y     = s_tdata[Y_LSB +: COORD_W];
    assign s_accept      = s_tvalid && s_tready;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            neighbor_count_reg <= KCFG_W'(12);
            point_count_reg    <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_NEIGHBOR_COUNT: neighbor_count_reg <= cfg_data[KCFG_W-1:0];
                CFG_POINT_COUNT:    point_count_reg    <= cfg_data;
                default:            point_count_reg    <= point_count_reg;
            endcase
        end
    end

    // Clamp the point count and the neighbor count for the next query.
    always_comb begin
        pc_clamp = (point_count_reg > PCFG_W'(MAX_POINTS)) ? PCFG_W'(MAX_POINTS)
                                                          : point_count_reg;
        pc_minus1 = pc_clamp - PCFG_W'(1);
        k_lim     = PCFG_W'(neighbor_count_reg);
        if (k_lim > PCFG_W'(MAX_NEIGHBORS)) begin
            k_lim = PCFG_W'(MAX_NEIGHBORS);
        end
        if (k_lim > pc_minus1) begin
            k_lim = pc_minus1;
        end
        if (k_lim == '0) begin
            k_lim = PCFG_W'(1);
        end
        k_eff_next  = k_lim[NBR_W-1:0];
        query_empty = (pc_clamp < PCFG_W'(2)) ||
                      (PCFG_W'(s_point_index) >= pc_clamp);
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // Next state, memory port and output loading.
    always_comb begin
        state_next     = state_reg;
        scan_cnt_next  = scan_cnt_reg;
        drain_cnt_next = drain_cnt_reg;
        rank_next      = rank_reg;
        s_tready       = 1'b0;
        mem_we         = 1'b0;
        rd_addr        = s_point_index;
        issue_valid    = 1'b0;
        cells_clear    = 1'b0;
        cells_shift    = 1'b0;
        out_load       = 1'b0;
        out_idx_next   = cell_link[0].ent.idx;
        out_dist_next  = cell_link[0].ent.sq_dist;
        out_rank_next  = rank_reg;
        out_found_next = 1'b1;
        out_last_next  = !right_ent[0].valid;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == CMD_LOAD) begin
                        mem_we = 1'b1;
                    end else begin
                        cells_clear = 1'b1;
                        state_next  = query_empty ? ST_NONE : ST_NODE;
                    end
                end
            end
            ST_NODE: begin
                scan_cnt_next = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                rd_addr       = scan_cnt_reg[POINT_W-1:0];
                issue_valid   = (rd_addr != node_idx_reg);
                scan_cnt_next = scan_cnt_reg + PCFG_W'(1);
                if (scan_cnt_reg == pc_reg - PCFG_W'(1)) begin
                    drain_cnt_next = '0;
                    state_next     = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                drain_cnt_next = drain_cnt_reg + DRAIN_W'(1);
                if (drain_cnt_reg == DRAIN_W'(DRAIN_CYCLES - 1)) begin
                    rank_next  = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    cells_shift = 1'b1;
                    rank_next   = rank_reg + RANK_W'(1);
                    if (!right_ent[0].valid) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_NONE: begin
                out_idx_next   = '0;
                out_dist_next  = '0;
                out_rank_next  = '0;
                out_found_next = 1'b0;
                out_last_next  = 1'b1;
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            drain_cnt_reg <= '0;
            rank_reg      <= '0;
            k_eff_reg     <= NBR_W'(1);
            pc_reg        <= '0;
            node_idx_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            drain_cnt_reg <= drain_cnt_next;
            rank_reg      <= rank_next;
            if (s_accept && (s_tuser == CMD_QUERY)) begin
                k_eff_reg    <= k_eff_next;
                pc_reg       <= pc_clamp;
                node_idx_reg <= s_point_index;
            end
        end
    end

    // Point memory: one write port for loads, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            point_mem[s_point_index] <= {s_coord_y, s_coord_x};
        end
        rd_data_reg <= point_mem[rd_addr];
    end

    // Read stage tags and the captured query node.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= issue_valid;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_addr;
        if (state_reg == ST_NODE) begin
            node_x_reg <= rd_data_reg[COORD_W-1:0];
            node_y_reg <= rd_data_reg[2*COORD_W-1:COORD_W];
        end
    end

    knn_dist u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (rd_valid_reg),
        .in_idx   (rd_idx_reg),
        .node_x   (node_x_reg),
        .node_y   (node_y_reg),
        .pt_x     (rd_data_reg[COORD_W-1:0]),
        .pt_y     (rd_data_reg[2*COORD_W-1:COORD_W]),
        .cand     (cand)
    );

    // Row of sorting cells, nearest at the head.
    for (genvar i = 0; i < MAX_NEIGHBORS; i++) begin : g_cell
        knn_link_t left_link;

        if (i == 0) begin : g_head
            assign left_link = '0;
        end else begin : g_body
            assign left_link = cell_link[i-1];
        end

        if (i == MAX_NEIGHBORS - 1) begin : g_tail
            assign right_ent[i] = '0;
        end else begin : g_inner
            assign right_ent[i] = cell_link[i+1].ent;
        end

        knn_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .enable   (k_eff_reg > NBR_W'(i)),
            .clear    (cells_clear),
            .shift    (cells_shift),
            .cand     (cand),
            .left_in  (left_link),
            .right_in (right_ent[i]),
            .link_out (cell_link[i])
        );
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_idx_reg   <= out_idx_next;
            out_dist_reg  <= out_dist_next;
            out_rank_reg  <= out_rank_next;
            out_found_reg <= out_found_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_rank_reg, out_dist_reg, out_idx_reg};
    assign m_tuser  = out_found_reg;
    assign m_tlast  = out_last_reg;

    // Checks on the sorting row and the sequencer.
    assign row_in_order = cell_link[0].ent.valid &&
                          (cell_link[0].ent.sq_dist <= right_ent[0].sq_dist);
    assign scan_phase   = (state_reg == ST_SCAN) || (state_reg == ST_DRAIN);
    assign emit_last    = cells_shift && out_last_next;

    `KNN_ASSERT_IMP(a_head_valid_on_emit, aclk, aresetn, state_reg == ST_EMIT, cell_link[0].ent.valid)
    `KNN_ASSERT_IMP(a_row_sorted, aclk, aresetn, right_ent[0].valid, row_in_order)
    `KNN_ASSERT_IMP(a_cand_in_scan, aclk, aresetn, cand.valid, scan_phase)
    `KNN_ASSERT_NXT(a_last_ends_emit, aclk, aresetn, emit_last, state_reg == ST_IDLE)

endmodule

// ===== dv/knn_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_result_checker
// Predicts and checks the result stream of the nearest neighbor selector.
// ----------------------------------------------------------------------------
// The checker watches the configuration, request and result channels. Each
// accepted load updates its own copy of the point store. Each accepted query
// appends the expected neighbors, nearest first, to a queue. Each accepted
// result is compared field by field with the oldest entry of that queue.
// ----------------------------------------------------------------------------
module knn_result_checker
    import knn_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [PCFG_W-1:0] cfg_data,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [47:0]       s_tdata,
    input  logic              s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [47:0]       m_tdata,
    input  logic              m_tuser,
    input  logic              m_tlast,
    output int                fail_count,
    output int                pending_count
);

    localparam int                K_RESET     = 12;
    localparam int                MAX_REPORTS = 10;
    localparam logic [DIST_W-1:0] DIST_SAT    = '1;

    // One expected or observed neighbor.
    typedef struct {
        logic [POINT_W-1:0] neighbor_index;
        logic [DIST_W-1:0]  squared_distance;
        logic [RANK_W-1:0]  rank;
        logic               found;
        logic               last;
    } nbr_result_t;

    logic signed [COORD_W-1:0] x_mem [MAX_POINTS];
    logic signed [COORD_W-1:0] y_mem [MAX_POINTS];
    logic [KCFG_W-1:0]         k_reg;
    logic [PCFG_W-1:0]         pc_reg;
    nbr_result_t               neighbor_q [$];
    nbr_result_t               seen_result;
    int                        mismatch_count = 0;

    // Squared Euclidean distance between two stored points, saturated.
    function automatic logic [DIST_W-1:0] point_distance(input int a, input int b);
        longint dx;
        longint dy;
        longint d;
        dx = longint'(x_mem[a]) - longint'(x_mem[b]);
        dy = longint'(y_mem[a]) - longint'(y_mem[b]);
        d  = dx * dx + dy * dy;
        if (d > longint'(DIST_SAT)) begin
            return DIST_SAT;
        end
        return DIST_W'(d);
    endfunction

    // Scan the points in use and queue the k nearest to the node, ties going
    // to the smaller index.
    task automatic predict_neighbors(input logic [POINT_W-1:0] node);
        logic [DIST_W-1:0]  best_dist [MAX_NEIGHBORS];
        logic [POINT_W-1:0] best_idx  [MAX_NEIGHBORS];
        logic [DIST_W-1:0]  d;
        nbr_result_t        r;
        int                 span;
        int                 k;
        int                 cnt;
        int                 p;
        int                 i;
        int                 j;
        span = (int'(pc_reg) > MAX_POINTS) ? MAX_POINTS : int'(pc_reg);
        r = '{default: '0};

        // No other point, or the node is not in use: one empty result.
        if (span < 2 || int'(node) >= span) begin
            r.last = 1'b1;
            neighbor_q.insert(neighbor_q.size(), r);
            return;
        end

        k = int'(k_reg);
        if (k > MAX_NEIGHBORS) k = MAX_NEIGHBORS;
        if (k > span - 1) k = span - 1;
        if (k < 1) k = 1;

        cnt = 0;
        for (i = 0; i < span; i++) begin
            if (i == int'(node)) continue;
            d = point_distance(int'(node), i);
            if (cnt == k && d >= best_dist[cnt-1]) continue;
            p = 0;
            while (p < cnt && best_dist[p] <= d) p++;
            if (cnt < k) cnt++;
            for (j = cnt - 1; j > p; j--) begin
                best_dist[j] = best_dist[j-1];
                best_idx[j]  = best_idx[j-1];
            end
            best_dist[p] = d;
            best_idx[p]  = POINT_W'(i);
        end

        for (i = 0; i < cnt; i++) begin
            r.neighbor_index   = best_idx[i];
            r.squared_distance = best_dist[i];
            r.rank             = RANK_W'(i);
            r.found            = 1'b1;
            r.last             = (i == cnt - 1);
            neighbor_q.insert(neighbor_q.size(), r);
        end
    endtask

    // Compare one observed result with the oldest expectation.
    function automatic void check_result(input nbr_result_t got);
        nbr_result_t want;
        if (neighbor_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("ERROR: unexpected result idx %0d dist %0d rank %0d found %0b last %0b",
                         got.neighbor_index, got.squared_distance, got.rank, got.found,
                         got.last);
            end
            return;
        end
        want = neighbor_q.pop_front();
        if (got.neighbor_index !== want.neighbor_index ||
            got.squared_distance !== want.squared_distance ||
            got.rank !== want.rank || got.found !== want.found ||
            got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("ERROR: expected idx %0d dist %0d rank %0d found %0b last %0b",
                         want.neighbor_index, want.squared_distance, want.rank, want.found,
                         want.last);
                $display("       actual   idx %0d dist %0d rank %0d found %0b last %0b",
                         got.neighbor_index, got.squared_distance, got.rank, got.found,
                         got.last);
            end
        end
    endfunction

    // Track configuration, requests and results at every clock edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            k_reg  = KCFG_W'(K_RESET);
            pc_reg = '0;
            neighbor_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_NEIGHBOR_COUNT) begin
                    k_reg = cfg_data[KCFG_W-1:0];
                end else begin
                    pc_reg = cfg_data;
                end
            end

            if (s_tvalid && s_tready) begin
                if (s_tuser == CMD_LOAD) begin
                    x_mem[s_tdata[POINT_W-1:0]] = s_tdata[POINT_W +: COORD_W];
                    y_mem[s_tdata[POINT_W-1:0]] = s_tdata[POINT_W+COORD_W +: COORD_W];
                end else begin
                    predict_neighbors(s_tdata[POINT_W-1:0]);
                end
            end

            if (m_tvalid && m_tready) begin
                seen_result.neighbor_index   = m_tdata[POINT_W-1:0];
                seen_result.squared_distance = m_tdata[POINT_W +: DIST_W];
                seen_result.rank             = m_tdata[POINT_W+DIST_W +: RANK_W];
                seen_result.found            = m_tuser;
                seen_result.last             = m_tlast;
                check_result(seen_result);
            end
        end
        pending_count <= neighbor_q.size();
        fail_count    <= mismatch_count;
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the nearest neighbor selector.
// ----------------------------------------------------------------------------
// A short directed part covers empty stores, nodes not in use, extreme
// coordinates, ties and the clamping of k. Random phases then set k and the
// point count, load every point in use, and mix queries with reloads. The
// sender works in bursts, the receiver stalls on its own pattern and once
// holds off for a long stretch. Checking is done by the result checker.
// ----------------------------------------------------------------------------
module tb_top;
    import knn_pkg::*;

    localparam int TIMEOUT_NS   = 20_000_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int END_CYCLES   = 64;
    localparam int HOLD_CYCLES  = 3000;
    localparam int HOLD_PHASE   = 3;
    localparam int RANDOM_ITEMS = 280;
    localparam int PAD_W        = 48 - POINT_W - 2 * COORD_W;

    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

    // Receiver stall patterns.
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_index = CFG_NEIGHBOR_COUNT;
    logic [PCFG_W-1:0] cfg_data  = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [47:0]       s_tdata   = '0;
    logic              s_tuser   = CMD_LOAD;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [47:0]       m_tdata;
    logic              m_tuser;
    logic              m_tlast;
    int                fail_count;
    int                pending_count;

    bit loaded [MAX_POINTS];
    int burst_left = 0;
    int sent_count = 0;
    int span_now   = 0;
    bit hold_req   = 1'b0;
    bit hold_taken = 1'b0;

    k_nearest_neighbor_select dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    knn_result_checker result_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 50 MHz clock.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Coordinates: a small range to force ties, a medium range, the extremes,
    // or any value.
    function automatic logic signed [COORD_W-1:0] rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            return COORD_W'(int'($urandom_range(0, 6)) - 3);
        end else if (r < 55) begin
            return COORD_W'(int'($urandom_range(0, 600)) - 300);
        end else if (r < 70) begin
            case ($urandom_range(0, 3))
                0: return COORD_MIN;
                1: return COORD_MAX;
                2: return '0;
                default: return '1;
            endcase
        end
        return COORD_W'($urandom());
    endfunction

    // Offer one request; the sender may idle between bursts of random length.
    task automatic send_req(input logic cmd, input int idx,
                            input logic signed [COORD_W-1:0] cx,
                            input logic signed [COORD_W-1:0] cy);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {PAD_W'(0), cy, cx, POINT_W'(idx)};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        sent_count++;
        if (cmd == CMD_LOAD) loaded[idx] = 1'b1;
    endtask

    task automatic load_point(input int idx, input logic signed [COORD_W-1:0] cx,
                              input logic signed [COORD_W-1:0] cy);
        send_req(CMD_LOAD, idx, cx, cy);
    endtask

    // Query coordinates are ignored by the block, so they carry noise.
    task automatic query_node(input int idx);
        send_req(CMD_QUERY, idx, rand_coord(), rand_coord());
    endtask

    // Stop sending and wait until every expected result has been taken.
    task automatic wait_idle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write both registers back to back, keeping the write valid high.
    task automatic set_config(input int k, input int pc);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_NEIGHBOR_COUNT;
        cfg_data  <= PCFG_W'(k);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= CFG_POINT_COUNT;
        cfg_data  <= PCFG_W'(pc);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        span_now = (pc > MAX_POINTS) ? MAX_POINTS : pc;
    endtask

    // New setting while idle, then load every point in use not yet written.
    task automatic start_phase(input int k, input int pc);
        int i;
        wait_idle();
        set_config(k, pc);
        for (i = 0; i < span_now; i++) begin
            if (!loaded[i]) load_point(i, rand_coord(), rand_coord());
        end
    endtask

    // Receiver: changing stall patterns, plus one long hold-off on request.
    initial begin
        rx_mode_t mode;
        int       span;
        wait (aresetn);
        forever begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                mode = rx_mode_t'($urandom_range(0, 3));
                span = $urandom_range(8, 120);
                repeat (span) begin
                    case (mode)
                        RX_OPEN:   m_tready <= 1'b1;
                        RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                        RX_SPARSE: m_tready <= ($urandom_range(0, 5) == 0);
                        default:   m_tready <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    // Watchdog.
    initial begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        int phase;
        int pick;
        int k;
        int pc;
        int n;
        int directed_count;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        wait_idle();

        // Empty store after reset, with the reset value of k.
        query_node(0);

        // Extreme corners, a duplicate point for a tie, the top index.
        load_point(0, COORD_MIN, COORD_MIN);
        load_point(1, COORD_MAX, COORD_MAX);
        load_point(2, '0, '0);
        load_point(3, '0, '0);
        load_point(4, COORD_MIN, COORD_MAX);
        load_point(5, COORD_W'(1), '1);
        load_point(MAX_POINTS - 1, COORD_MAX, COORD_MIN);

        // A single point in use has no neighbor.
        start_phase(12, 1);
        query_node(0);

        // k above the number of other points, and nodes not in use.
        start_phase(MAX_NEIGHBORS, 6);
        for (n = 0; n < 6; n++) query_node(n);
        query_node(MAX_POINTS - 1);
        query_node(6);

        // Smallest k, with a tie at distance zero; then k of zero.
        start_phase(1, 6);
        query_node(2);
        query_node(5);
        start_phase(0, 6);
        query_node(1);
        directed_count = sent_count;

        // Random phases with small to medium point counts.
        phase = 0;
        while (sent_count < directed_count + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)       pc = $urandom_range(0, 1);
            else if (pick < 80) pc = $urandom_range(2, 48);
            else                pc = $urandom_range(49, 120);
            pick = $urandom_range(0, 99);
            if (pick < 80)      k = $urandom_range(1, MAX_NEIGHBORS);
            else if (pick < 90) k = 0;
            else                k = $urandom_range(MAX_NEIGHBORS + 1, 31);
            start_phase(k, pc);

            // One phase runs with the receiver held off so the block backs up.
            if (phase == HOLD_PHASE) hold_req = 1'b1;
            n = (phase == HOLD_PHASE) ? 30 : $urandom_range(4, 14);
            repeat (n) begin
                pick = $urandom_range(0, 99);
                if (pick < 65 && span_now > 0) begin
                    query_node($urandom_range(0, span_now - 1));
                end else if (pick < 75) begin
                    query_node($urandom_range(0, MAX_POINTS - 1));
                end else if (pick < 88 && span_now > 0) begin
                    load_point($urandom_range(0, span_now - 1), rand_coord(), rand_coord());
                end else begin
                    load_point($urandom_range(0, MAX_POINTS - 1), rand_coord(), rand_coord());
                end
            end
            phase++;
        end

        wait_idle();
        repeat (END_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
